// File: hw/rtl/sic_pkg.sv
// shared types and constants for the streaming inversion counter
package sic_pkg;

  localparam int VALUE_W   = 13;
  localparam int NODE_W    = 13;
  localparam int GREATER_W = 12;
  localparam int TOTAL_W   = 23;
  localparam int EPOCH_W   = 8;

  localparam logic [VALUE_W-1:0]   LIMIT_RESET = 13'd4096;
  localparam logic [NODE_W-1:0]    NODE_MAX    = 13'd8191;
  localparam logic [GREATER_W-1:0] GREATER_MAX = 12'd4095;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = 23'd8388607;
  localparam logic [EPOCH_W-1:0]   EPOCH_MAX   = 8'd255;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [NODE_W-1:0]  count;
  } node_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_QLEFT  = 7'b0000100,
    S_QRIGHT = 7'b0001000,
    S_UPD_RD = 7'b0010000,
    S_UPD_WR = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

endpackage

// File: hw/rtl/sic_ram.sv
// generic single write port, single read port ram with registered read
module sic_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/streaming_inversion_counter.sv
// top level of the streaming inversion counter
// Takes one value per transaction and returns how many earlier values were strictly greater
// (within 1..value_limit) plus the running inversion total. All work goes through one count
// tree memory of 2*MAX_VALUES nodes with one read and one write per cycle, in
// L = log2(MAX_VALUES)+1 levels. The range query walks up the levels from the leaves,
// reading the left and the right border node of each level, then the update walks from
// leaf to root, reading and writing back each node, and the result is registered last.
// An item is accepted only in idle, so the block accepts nothing while one is in work.
// A restart (first) is handled by bumping an epoch tag stored with every node; after
// reset, and on every 256th restart when the tag wraps, a clearing pass over all
// 2*MAX_VALUES nodes sweeps the memory before work goes on.
// The result register lets the next transaction enter while a result waits to be taken.
module streaming_inversion_counter #(
  parameter int MAX_VALUES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sic_pkg::VALUE_W-1:0]     value_limit,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [sic_pkg::VALUE_W-1:0]     value,
  input  logic                            first,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [sic_pkg::GREATER_W-1:0]   greater_before,
  output logic [sic_pkg::TOTAL_W-1:0]     inversions_total
);

  localparam int AW    = $clog2(MAX_VALUES) + 2;
  localparam int MW    = AW - 1;
  localparam int DEPTH = 2 * MAX_VALUES;
  localparam int XW    = (AW > sic_pkg::VALUE_W + 1) ? AW : sic_pkg::VALUE_W + 1;
  localparam logic [XW-1:0] NX = XW'(MAX_VALUES);
  localparam logic [AW-1:0] NA = AW'(MAX_VALUES);
  localparam logic [MW-1:0] LAST_ADDR = MW'(DEPTH - 1);

  sic_pkg::state_t state;

  logic [sic_pkg::VALUE_W-1:0]   limit;
  logic [sic_pkg::EPOCH_W-1:0]   epoch;
  logic [sic_pkg::TOTAL_W-1:0]   total;
  logic [sic_pkg::GREATER_W-1:0] acc;
  logic [AW-1:0]                 lo;
  logic [AW-1:0]                 hi;
  logic [MW-1:0]                 node;
  logic [MW-1:0]                 clr_addr;
  logic                          pend;
  logic                          hold;

  logic [XW-1:0] lim_x;
  logic [XW-1:0] v_x;
  logic [AW-1:0] lim_a;
  logic [AW-1:0] v_a;
  logic [AW-1:0] hi_dec;
  logic [MW-1:0] node_up;

  logic            wr_en;
  logic [MW-1:0]   wr_addr;
  sic_pkg::node_t  wr_data;
  logic            rd_en;
  logic [MW-1:0]   rd_addr;
  sic_pkg::node_t  rd_data;

  logic [sic_pkg::NODE_W-1:0]    rd_count;
  logic [sic_pkg::NODE_W-1:0]    inc;
  logic [sic_pkg::GREATER_W+1:0] acc_sum;
  logic [sic_pkg::TOTAL_W:0]     total_wide;
  logic [sic_pkg::TOTAL_W-1:0]   total_sum;
  logic                          accept;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != sic_pkg::S_IDLE);
  assign accept     = item_valid && !item_stall;

  // clamp limit and value
  always_comb begin
    lim_x = XW'(limit);
    if (lim_x == '0) begin
      lim_x = XW'(1);
    end
    if (lim_x > NX) begin
      lim_x = NX;
    end
    v_x = XW'(value);
    if (v_x == '0) begin
      v_x = XW'(1);
    end
    if (v_x > lim_x) begin
      v_x = lim_x;
    end
    lim_a = lim_x[AW-1:0];
    v_a   = v_x[AW-1:0];
  end

  assign hi_dec  = hi - AW'(1);
  assign node_up = node >> 1;

  assign rd_count = (rd_data.epoch == epoch) ? rd_data.count : '0;
  assign inc      = (rd_count == sic_pkg::NODE_MAX) ? rd_count : rd_count + 1'b1;
  assign acc_sum  = (sic_pkg::GREATER_W+2)'(acc) + (sic_pkg::GREATER_W+2)'(rd_count);

  assign total_wide = (sic_pkg::TOTAL_W+1)'(total) + (sic_pkg::TOTAL_W+1)'(acc);
  assign total_sum  = total_wide[sic_pkg::TOTAL_W] ? sic_pkg::TOTAL_MAX
                                                   : total_wide[sic_pkg::TOTAL_W-1:0];

  // memory port control
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = node;
    wr_data.epoch = epoch;
    wr_data.count = inc;
    rd_en         = 1'b0;
    rd_addr       = lo[MW-1:0];
    case (state)
      sic_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      sic_pkg::S_QLEFT: begin
        rd_en   = (lo < hi) && lo[0];
        rd_addr = lo[MW-1:0];
      end
      sic_pkg::S_QRIGHT: begin
        rd_en   = hi[0];
        rd_addr = hi_dec[MW-1:0];
      end
      sic_pkg::S_UPD_RD: begin
        rd_en   = 1'b1;
        rd_addr = node;
      end
      sic_pkg::S_UPD_WR: begin
        wr_en   = 1'b1;
        rd_en   = (node_up != '0);
        rd_addr = node_up;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  sic_ram #(
    .WIDTH ($bits(sic_pkg::node_t)),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sic_pkg::S_CLEAR;
      limit        <= sic_pkg::LIMIT_RESET;
      epoch        <= '0;
      total        <= '0;
      clr_addr     <= '0;
      pend         <= 1'b0;
      hold         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= value_limit;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      pend <= rd_en && ((state == sic_pkg::S_QLEFT) || (state == sic_pkg::S_QRIGHT));
      if (pend) begin
        acc <= (acc_sum > (sic_pkg::GREATER_W+2)'(sic_pkg::GREATER_MAX))
               ? sic_pkg::GREATER_MAX : acc_sum[sic_pkg::GREATER_W-1:0];
      end
      case (state)
        sic_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            clr_addr <= '0;
            hold     <= 1'b0;
            state    <= hold ? sic_pkg::S_QLEFT : sic_pkg::S_IDLE;
          end
        end
        sic_pkg::S_IDLE: begin
          if (accept) begin
            lo    <= NA + v_a;
            hi    <= NA + lim_a;
            node  <= MW'(NA + v_a - AW'(1));
            acc   <= '0;
            state <= sic_pkg::S_QLEFT;
            if (first) begin
              total <= '0;
              if (epoch == sic_pkg::EPOCH_MAX) begin
                epoch <= '0;
                hold  <= 1'b1;
                state <= sic_pkg::S_CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end
          end
        end
        sic_pkg::S_QLEFT: begin
          if (lo < hi) begin
            if (lo[0]) begin
              lo <= lo + AW'(1);
            end
            state <= sic_pkg::S_QRIGHT;
          end else begin
            state <= sic_pkg::S_UPD_RD;
          end
        end
        sic_pkg::S_QRIGHT: begin
          lo    <= lo >> 1;
          hi    <= (hi[0] ? hi_dec : hi) >> 1;
          state <= sic_pkg::S_QLEFT;
        end
        sic_pkg::S_UPD_RD: begin
          state <= sic_pkg::S_UPD_WR;
        end
        sic_pkg::S_UPD_WR: begin
          node <= node_up;
          if (node_up == '0) begin
            state <= sic_pkg::S_DONE;
          end
        end
        sic_pkg::S_DONE: begin
          if (!result_valid || !result_stall) begin
            greater_before   <= acc;
            inversions_total <= total_sum;
            total            <= total_sum;
            result_valid     <= 1'b1;
            state            <= sic_pkg::S_IDLE;
          end
        end
        default: begin
          state <= sic_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == sic_pkg::S_QLEFT || state == sic_pkg::S_QRIGHT) |-> !wr_en)
    else $error("tree written during range query");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != sic_pkg::S_IDLE))
    else $error("sequencer stayed idle after a transaction");

  a_total_monotone: assert property (@(posedge clk) disable iff (rst)
    !(accept && first) |=> (total >= $past(total)))
    else $error("running total decreased without restart");

  a_update_node_valid: assert property (@(posedge clk) disable iff (rst)
    (state == sic_pkg::S_UPD_WR) |-> (node != '0))
    else $error("update walked past the root");
`endif

endmodule

// File: tb/sv/tb.sv
// testbench for the streaming inversion counter: directed table, restart run, random sequences, fill run
`timescale 1ns / 100ps
module tb;

  localparam int TREE_LEAVES = 4096;
  localparam int RANDOM_ITEMS = 1080;
  localparam int STORM_ITEMS = 300;
  localparam int FILL_ITEMS = 360;
  localparam int PROBE_ITEMS = 40;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 100;
  localparam int SCRIPT_ROWS = 33;
  localparam longint TIMEOUT_NS = 64'd40_000_000;

  typedef logic [sic_pkg::VALUE_W-1:0]   value_t;
  typedef logic [sic_pkg::GREATER_W-1:0] greater_t;
  typedef logic [sic_pkg::TOTAL_W-1:0]   total_t;
  typedef logic [sic_pkg::NODE_W-1:0]    count_t;

  typedef struct packed {
    greater_t greater;
    total_t   total;
  } tally_t;

  typedef struct {
    bit       is_cfg;
    value_t   value;
    logic     first;
    bit       typed;
    greater_t greater;
    total_t   total;
  } script_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  value_t   value_limit = sic_pkg::LIMIT_RESET;
  logic     item_valid = 1'b0;
  logic     item_stall;
  value_t   value = '0;
  logic     first = 1'b0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  greater_t greater_before;
  total_t   inversions_total;

  // model of the block
  count_t seen_count [1:2*TREE_LEAVES-1];
  total_t running_sum = '0;
  value_t limit_now = sic_pkg::LIMIT_RESET;

  tally_t      awaited_tallies [$];
  script_row_t script [0:SCRIPT_ROWS-1];
  int          miscompares = 0;
  int          results_taken = 0;
  int          burst_left = 0;

  streaming_inversion_counter #(
    .MAX_VALUES(TREE_LEAVES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .value_limit(value_limit),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .value(value),
    .first(first),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .greater_before(greater_before),
    .inversions_total(inversions_total)
  );

  always #5 clk = ~clk;

  function automatic void clear_counts();
    foreach (seen_count[i]) seen_count[i] = '0;
  endfunction

  function automatic int clamp_limit(input value_t lim);
    int eff;
    eff = int'(lim);
    if (eff < 1) eff = 1;
    if (eff > TREE_LEAVES) eff = TREE_LEAVES;
    return eff;
  endfunction

  function automatic tally_t rank_value(input value_t raw, input logic restart);
    int lim;
    int v;
    int lo;
    int hi;
    int node;
    int greater;
    int total;
    tally_t res;
    lim = clamp_limit(limit_now);
    if (restart) begin
      clear_counts();
      running_sum = '0;
    end
    v = int'(raw);
    if (v < 1) v = 1;
    if (v > lim) v = lim;
    // count recorded values v+1..lim over the heap-indexed tree
    greater = 0;
    lo = TREE_LEAVES + v;
    hi = TREE_LEAVES + lim;
    while (lo < hi) begin
      if (lo % 2 == 1) begin
        greater += int'(seen_count[lo]);
        lo++;
      end
      if (hi % 2 == 1) begin
        hi--;
        greater += int'(seen_count[hi]);
      end
      lo = lo / 2;
      hi = hi / 2;
    end
    if (greater > int'(sic_pkg::GREATER_MAX)) greater = int'(sic_pkg::GREATER_MAX);
    total = int'(running_sum) + greater;
    if (total > int'(sic_pkg::TOTAL_MAX)) total = int'(sic_pkg::TOTAL_MAX);
    running_sum = total_t'(total);
    for (node = TREE_LEAVES + v - 1; node >= 1; node = node / 2) begin
      if (seen_count[node] != sic_pkg::NODE_MAX) seen_count[node] = seen_count[node] + 1'b1;
    end
    res.greater = greater_t'(greater);
    res.total = total_t'(total);
    return res;
  endfunction

  function automatic value_t pick_value(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return value_t'($urandom_range(1, lim));
    if (r < 90) return '0;
    if (r < 95) return value_t'($urandom_range(lim, 8191));
    return value_t'($urandom_range(0, 8191));
  endfunction

  function automatic void flag_error(input string msg);
    miscompares++;
    if (miscompares <= 10) $display("%s", msg);
  endfunction

  task automatic offer_item(input value_t v, input logic f, input bit typed,
                            input greater_t tg, input total_t tt);
    tally_t want;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item_valid <= 1'b1;
    value <= v;
    first <= f;
    do @(posedge clk); while (item_stall);
    want = rank_value(v, f);
    if (typed) begin
      want.greater = tg;
      want.total = tt;
    end
    awaited_tallies.push_back(want);
  endtask

  task automatic write_limit(input value_t lim);
    item_valid <= 1'b0;
    while (awaited_tallies.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    value_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = lim;
  endtask

  always @(posedge clk) begin : result_check
    tally_t want;
    if (!rst && result_valid && !result_stall) begin
      results_taken++;
      if (awaited_tallies.size() == 0) begin
        flag_error($sformatf("unexpected result greater=%0d total=%0d",
                             greater_before, inversions_total));
      end else begin
        want = awaited_tallies.pop_front();
        if (greater_before !== want.greater)
          flag_error($sformatf("result %0d greater_before: expected %0d, got %0d",
                               results_taken, want.greater, greater_before));
        if (inversions_total !== want.total)
          flag_error($sformatf("result %0d inversions_total: expected %0d, got %0d",
                               results_taken, want.total, inversions_total));
      end
    end
  end

  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        // one long hold-off so the block backs up and stalls its input
        if (!held && results_taken >= 100) begin
          held = 1'b1;
          result_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ~result_stall;
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int fed;
    int r;
    int eff;
    int nseq;
    int len;
    bit keep;
    bit restart;
    value_t new_lim;

    clear_counts();
    script = '{
      '{1'b0, 13'd4096, 1'b1, 1'b1, 12'd0, 23'd0},
      '{1'b0, 13'd1,    1'b0, 1'b1, 12'd1, 23'd1},
      '{1'b0, 13'd0,    1'b0, 1'b1, 12'd1, 23'd2},
      '{1'b0, 13'd8191, 1'b0, 1'b1, 12'd0, 23'd2},
      '{1'b0, 13'd2048, 1'b0, 1'b1, 12'd2, 23'd4},
      '{1'b0, 13'd4097, 1'b0, 1'b1, 12'd0, 23'd4},
      '{1'b0, 13'd1,    1'b1, 1'b1, 12'd0, 23'd0},
      '{1'b0, 13'd3,    1'b0, 1'b1, 12'd0, 23'd0},
      '{1'b0, 13'd2,    1'b0, 1'b1, 12'd1, 23'd1},
      '{1'b0, 13'd4095, 1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'h0AAA, 1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'h1555, 1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'h0555, 1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b1, 13'd1,    1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'd5,    1'b1, 1'b1, 12'd0, 23'd0},
      '{1'b0, 13'd1,    1'b0, 1'b1, 12'd0, 23'd0},
      '{1'b0, 13'd0,    1'b0, 1'b1, 12'd0, 23'd0},
      '{1'b1, 13'd0,    1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'd4096, 1'b0, 1'b1, 12'd0, 23'd0},
      '{1'b1, 13'd8191, 1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'd2,    1'b0, 1'b1, 12'd0, 23'd0},
      '{1'b0, 13'd1,    1'b0, 1'b1, 12'd1, 23'd1},
      '{1'b0, 13'd3000, 1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'd4000, 1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b1, 13'd100,  1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'd50,   1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b1, 13'd4097, 1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'd4096, 1'b1, 1'b1, 12'd0, 23'd0},
      '{1'b0, 13'd10,   1'b0, 1'b1, 12'd1, 23'd1},
      '{1'b1, 13'd2,    1'b0, 1'b0, 12'd0, 23'd0},
      '{1'b0, 13'd2,    1'b1, 1'b1, 12'd0, 23'd0},
      '{1'b0, 13'd1,    1'b0, 1'b1, 12'd1, 23'd1},
      '{1'b0, 13'd9,    1'b0, 1'b1, 12'd0, 23'd1}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) write_limit(script[i].value);
      else offer_item(script[i].value, script[i].first, script[i].typed,
                      script[i].greater, script[i].total);
    end

    // run of restarts, enough to wrap the restart tag
    write_limit(value_t'($urandom_range(1, 4096)));
    for (fed = 0; fed < STORM_ITEMS; fed++)
      offer_item(value_t'($urandom_range(0, 8191)), 1'b1, 1'b0, '0, '0);

    while (fed < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        0: new_lim = value_t'($urandom_range(4097, 8191));
        1: new_lim = value_t'($urandom_range(0, 1));
        2, 3, 4, 5: new_lim = value_t'($urandom_range(2, 64));
        default: new_lim = value_t'($urandom_range(1, 4096));
      endcase
      write_limit(new_lim);
      eff = clamp_limit(new_lim);
      keep = ($urandom_range(0, 4) == 0);
      nseq = $urandom_range(1, 4);
      for (int s = 0; s < nseq; s++) begin
        len = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : $urandom_range(4, 60);
        for (int k = 0; k < len; k++) begin
          restart = (k == 0 && !(keep && s == 0)) || ($urandom_range(0, 49) == 0);
          offer_item(pick_value(eff), restart, 1'b0, '0, '0);
          fed++;
        end
      end
    end

    // fill the upper half, then probe below it
    write_limit(13'd4096);
    for (int k = 0; k < FILL_ITEMS; k++)
      offer_item(value_t'($urandom_range(2049, 4096)), (k == 0), 1'b0, '0, '0);
    for (int k = 0; k < PROBE_ITEMS; k++)
      offer_item(13'd2048, 1'b0, 1'b0, '0, '0);

    item_valid <= 1'b0;
    while (awaited_tallies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (miscompares == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
